FILE: rtl/core/osca_pkg.sv
// ----------------------------------------------------------------------------
// Octree sphere cell assignment package
// Shared widths, constants and types for the octree cell assignment block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package osca_pkg;

  // Depth of the tree below the root (at least one level).
  localparam int unsigned LAYERS    = 2;
  // Root half size in Q2.14: the root spans -0.5 to 0.5.
  localparam int unsigned ROOT_HALF = 8192;

  localparam int unsigned IdW   = 8;   // sphere id
  localparam int unsigned PosW  = 16;  // signed Q2.14 coordinate
  localparam int unsigned RadW  = 15;  // unsigned Q1.14 radius
  localparam int unsigned CellW = 7;   // breadth first cell index
  localparam int unsigned LvlW  = 2;   // tree level
  localparam int unsigned CntW  = 9;   // spheres per cell
  localparam int unsigned CntrW = 15;  // signed cell centre
  localparam int unsigned HalfW = 14;  // cell half size
  localparam int unsigned SumW  = 19;  // containment bound arithmetic

  // Cells in a full tree: the root and the LAYERS levels below it.
  localparam int unsigned NumCells = ((1 << (3 * (LAYERS + 1))) - 1) / 7;

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [CntrW-1:0] cntr_t;
  typedef logic [HalfW-1:0]        half_t;
  typedef logic [CellW-1:0]        cell_t;
  typedef logic [LvlW-1:0]         lvl_t;
  typedef logic [CntW-1:0]         cnt_t;

  // Per-axis containment flags; bit 0 is x, bit 1 is y, bit 2 is z.
  typedef struct packed {
    logic [2:0] parent_ok;
    logic [2:0] lo_ok;
    logic [2:0] hi_ok;
  } fit_t;

  typedef struct packed {
    cell_t node;
    lvl_t  level;
    logic  outside;
  } srch_res_t;

  typedef struct packed {
    logic  moved;
    cell_t old_cell;
    logic  had_old;
    logic  became_occ;
    logic  became_emp;
  } occ_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/osca_fit_unit.sv
// ----------------------------------------------------------------------------
// Octree containment unit
// Tests a sphere against a parent cell and both child halves on every axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osca_fit_unit (
  input  osca_pkg::pos_t             pos_i [3],
  input  logic [osca_pkg::RadW-1:0]  radius_i,
  input  osca_pkg::cntr_t            centre_i [3],
  input  osca_pkg::half_t            half_i,
  output osca_pkg::fit_t             fit_o
);
  import osca_pkg::*;

  typedef logic signed [SumW-1:0] sum_t;

  sum_t r_s;
  sum_t h_s;
  sum_t p_s    [3];
  sum_t c_s    [3];
  sum_t lo_b   [3];
  sum_t mid_lo [3];
  sum_t mid_hi [3];
  sum_t hi_b   [3];

  // The low child spans c-h..c and the high child c..c+h, both inclusive and
  // shrunk by the radius.
  always_comb begin
    r_s = sum_t'({1'b0, radius_i});
    h_s = sum_t'({1'b0, half_i});
    for (int a = 0; a < 3; a++) begin
      p_s[a]    = sum_t'(pos_i[a]);
      c_s[a]    = sum_t'(centre_i[a]);
      lo_b[a]   = c_s[a] - h_s + r_s;
      mid_lo[a] = c_s[a] - r_s;
      mid_hi[a] = c_s[a] + r_s;
      hi_b[a]   = c_s[a] + h_s - r_s;
      fit_o.parent_ok[a] = (p_s[a] >= lo_b[a]) && (p_s[a] <= hi_b[a]);
      fit_o.lo_ok[a]     = (p_s[a] >= lo_b[a]) && (p_s[a] <= mid_lo[a]);
      fit_o.hi_ok[a]     = (p_s[a] >= mid_hi[a]) && (p_s[a] <= hi_b[a]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/osca_search.sv
// ----------------------------------------------------------------------------
// Octree descent sequencer
// Walks from the root one level per cycle through the shared containment unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osca_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  osca_pkg::pos_t             pos_i [3],
  input  logic [osca_pkg::RadW-1:0]  radius_i,
  output logic                       done_o,
  output osca_pkg::srch_res_t        res_o
);
  import osca_pkg::*;

  typedef enum logic [2:0] {
    SRCH_IDLE = 3'b001,
    SRCH_STEP = 3'b010,
    SRCH_DONE = 3'b100
  } srch_state_e;

  localparam half_t RootHalf = half_t'(ROOT_HALF);
  localparam lvl_t  LastLvl  = lvl_t'(LAYERS - 1);

  srch_state_e state_q, state_d;
  lvl_t        lvl_q, lvl_d;
  cntr_t       cntr_q [3];
  cntr_t       cntr_d [3];
  cell_t       cell_q, cell_d;
  cell_t       pos_q, pos_d;
  cell_t       base_q, base_d;
  logic        outside_q, outside_d;

  half_t       half;
  half_t       quarter;
  fit_t        fit;
  logic        last_step;
  logic        child_fits;
  logic [2:0]  sel;
  cell_t       child_pos;

  assign half    = RootHalf >> lvl_q;
  assign quarter = half >> 1;

  osca_fit_unit u_fit (
    .pos_i    (pos_i),
    .radius_i (radius_i),
    .centre_i (cntr_q),
    .half_i   (half),
    .fit_o    (fit)
  );

  // Above the last level the first fitting child in index order wins, so the
  // low half is taken when it fits. On the last level a later child replaces
  // an earlier one, so the high half is preferred.
  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    cntr_d    = cntr_q;
    cell_d    = cell_q;
    pos_d     = pos_q;
    base_d    = base_q;
    outside_d = outside_q;

    last_step  = (lvl_q == LastLvl);
    child_fits = &(fit.lo_ok | fit.hi_ok);
    for (int a = 0; a < 3; a++) begin
      sel[a] = last_step ? fit.hi_ok[a] : ~fit.lo_ok[a];
    end
    child_pos = {pos_q[CellW-4:0], sel[0], sel[1], sel[2]};

    unique case (state_q)
      SRCH_IDLE: begin
        if (start_i) begin
          state_d   = SRCH_STEP;
          lvl_d     = '0;
          cell_d    = '0;
          pos_d     = '0;
          base_d    = cell_t'(1);
          outside_d = 1'b0;
          for (int a = 0; a < 3; a++) begin
            cntr_d[a] = '0;
          end
        end
      end
      SRCH_STEP: begin
        priority if ((lvl_q == '0) && !(&fit.parent_ok)) begin
          outside_d = 1'b1;
          state_d   = SRCH_DONE;
        end else if (!child_fits) begin
          state_d = SRCH_DONE;
        end else begin
          lvl_d  = lvl_q + 1'b1;
          pos_d  = child_pos;
          cell_d = base_q + child_pos;
          base_d = {base_q[CellW-4:0], 3'b001};
          for (int a = 0; a < 3; a++) begin
            cntr_d[a] = sel[a] ? cntr_q[a] + cntr_t'({1'b0, quarter})
                               : cntr_q[a] - cntr_t'({1'b0, quarter});
          end
          if (last_step) begin
            state_d = SRCH_DONE;
          end
        end
      end
      SRCH_DONE: begin
        state_d = SRCH_IDLE;
      end
      default: begin
        state_d = SRCH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SRCH_IDLE;
      lvl_q     <= '0;
      cell_q    <= '0;
      pos_q     <= '0;
      base_q    <= cell_t'(1);
      outside_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cntr_q[a] <= '0;
      end
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      cell_q    <= cell_d;
      pos_q     <= pos_d;
      base_q    <= base_d;
      outside_q <= outside_d;
      cntr_q    <= cntr_d;
    end
  end

  assign done_o        = (state_q == SRCH_DONE);
  assign res_o.node    = cell_q;
  assign res_o.level   = lvl_q;
  assign res_o.outside = outside_q;

endmodule

`default_nettype wire

FILE: rtl/core/osca_occupancy.sv
// ----------------------------------------------------------------------------
// Octree occupancy tracker
// Holds each sphere's cell and the per-cell counts, updated read-modify-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osca_occupancy #(
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [IdxW-1:0]      idx_i,
  input  osca_pkg::cell_t      cell_i,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output osca_pkg::occ_res_t   res_o
);
  import osca_pkg::*;

  typedef enum logic [5:0] {
    OCC_IDLE  = 6'b000001,
    OCC_BALL  = 6'b000010,
    OCC_CHECK = 6'b000100,
    OCC_INC   = 6'b001000,
    OCC_DEC   = 6'b010000,
    OCC_DONE  = 6'b100000
  } occ_state_e;

  occ_state_e state_q, state_d;

  cell_t               ball_mem [DEPTH];
  cell_t               ball_rd_q;
  logic [DEPTH-1:0]    placed_q;
  logic                ball_we;

  cnt_t                cnt_mem [NumCells];
  cnt_t                cnt_rd_q;
  logic                cnt_rd_vld_q;
  logic [NumCells-1:0] cnt_vld_q;
  cell_t               cnt_raddr;
  cell_t               cnt_waddr;
  cnt_t                cnt_wdata;
  logic                cnt_we;
  cnt_t                cnt_cur;

  logic  moved_q, moved_d;
  logic  had_q, had_d;
  logic  occ_q, occ_d;
  logic  emp_q, emp_d;
  cell_t old_q, old_d;

  // A counter never written since reset reads as zero.
  assign cnt_cur = cnt_rd_vld_q ? cnt_rd_q : '0;

  always_comb begin
    state_d   = state_q;
    moved_d   = moved_q;
    had_d     = had_q;
    occ_d     = occ_q;
    emp_d     = emp_q;
    old_d     = old_q;
    cnt_raddr = cell_i;
    cnt_waddr = cell_i;
    cnt_wdata = cnt_cur + 1'b1;
    cnt_we    = 1'b0;
    ball_we   = 1'b0;

    unique case (state_q)
      OCC_IDLE: begin
        if (start_i) begin
          state_d = OCC_BALL;
        end
      end
      OCC_BALL: begin
        had_d   = placed_q[idx_i];
        state_d = OCC_CHECK;
      end
      OCC_CHECK: begin
        old_d   = had_q ? ball_rd_q : '0;
        moved_d = !had_q || (ball_rd_q != cell_i);
        occ_d   = 1'b0;
        emp_d   = 1'b0;
        state_d = (!had_q || (ball_rd_q != cell_i)) ? OCC_INC : OCC_DONE;
      end
      OCC_INC: begin
        occ_d     = (cnt_cur == '0);
        cnt_we    = 1'b1;
        ball_we   = 1'b1;
        cnt_raddr = old_q;
        state_d   = had_q ? OCC_DEC : OCC_DONE;
      end
      OCC_DEC: begin
        if (cnt_cur != '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = old_q;
          cnt_wdata = cnt_cur - 1'b1;
          emp_d     = (cnt_cur == cnt_t'(1));
        end
        state_d = OCC_DONE;
      end
      OCC_DONE: begin
        if (res_ready_i) begin
          state_d = OCC_IDLE;
        end
      end
      default: begin
        state_d = OCC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= OCC_IDLE;
      placed_q     <= '0;
      cnt_vld_q    <= '0;
      cnt_rd_vld_q <= 1'b0;
      moved_q      <= 1'b0;
      had_q        <= 1'b0;
      occ_q        <= 1'b0;
      emp_q        <= 1'b0;
      old_q        <= '0;
    end else begin
      state_q      <= state_d;
      moved_q      <= moved_d;
      had_q        <= had_d;
      occ_q        <= occ_d;
      emp_q        <= emp_d;
      old_q        <= old_d;
      cnt_rd_vld_q <= cnt_vld_q[cnt_raddr];
      if (ball_we) begin
        placed_q[idx_i] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ball_we) begin
      ball_mem[idx_i] <= cell_i;
    end
    ball_rd_q <= ball_mem[idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  assign res_valid_o      = (state_q == OCC_DONE);
  assign res_o.moved      = moved_q;
  assign res_o.old_cell   = old_q;
  assign res_o.had_old    = had_q;
  assign res_o.became_occ = occ_q;
  assign res_o.became_emp = emp_q;

endmodule

`default_nettype wire

FILE: rtl/core/octree_sphere_cell_assign.sv
// ----------------------------------------------------------------------------
// Octree sphere cell assignment
// Places spheres in the deepest enclosing octree cell and tracks occupancy.
// ----------------------------------------------------------------------------
// Each input beat carries a sphere id, its Q2.14 centre and its radius. The
// block finds the deepest cell, down to LAYERS levels below the root, that
// holds the whole sphere, records it as the sphere's cell and keeps a count
// of spheres per cell. Each output beat reports the cell, its level, whether
// the sphere moved, its previous cell and whether a cell became occupied or
// empty. Both channels use valid and stall; a beat passes when valid is high
// and stall is low.
// One beat is in flight at a time. The descent steps one level per cycle
// through the shared containment unit, then the occupancy update does a
// read-modify-write of the sphere and count memories in its ball, check,
// increment and decrement states. A result comes sooner when the descent
// stops early or the sphere stays put, and the next beat is taken on the
// edge that loads the result into the output register.
// A finished result waits in the output register while the receiver stalls;
// a new beat is taken and processed meanwhile, but cannot complete until
// the register drains. An id at or above BALLS is taken and dropped with no
// result. Reset empties every cell and marks all spheres as unplaced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module octree_sphere_cell_assign #(
  parameter int unsigned BALLS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [osca_pkg::IdW-1:0]    ball_id_i,
  input  osca_pkg::pos_t              pos_x_i,
  input  osca_pkg::pos_t              pos_y_i,
  input  osca_pkg::pos_t              pos_z_i,
  input  logic [osca_pkg::RadW-1:0]   radius_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output osca_pkg::cell_t             cell_id_o,
  output osca_pkg::lvl_t              cell_level_o,
  output logic                        moved_o,
  output osca_pkg::cell_t             old_cell_id_o,
  output logic                        had_old_cell_o,
  output logic                        cell_became_occupied_o,
  output logic                        old_cell_became_empty_o,
  output logic                        outside_root_o
);
  import osca_pkg::*;

  // Only ids that fit the id field can ever reach the sphere table.
  localparam int unsigned Depth = (BALLS < (1 << IdW)) ? BALLS : (1 << IdW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic            busy_q, busy_d;
  logic            in_acc;
  logic            in_range;
  pos_t            pos_q [3];
  logic [RadW-1:0] rad_q;
  logic [IdxW-1:0] idx_q;

  logic            srch_done;
  srch_res_t       srch_res;
  logic            occ_valid;
  logic            occ_ready;
  logic            occ_fire;
  occ_res_t        occ_res;

  logic            out_valid_q;
  srch_res_t       out_srch_q;
  occ_res_t        out_occ_q;

  // The result may leave the update unit whenever the output register is
  // empty or draining on this edge. A new beat is taken on that same edge.
  assign occ_ready  = ~out_valid_q | ~out_stall_i;
  assign occ_fire   = occ_valid & occ_ready;
  assign in_stall_o = busy_q & ~occ_fire;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_range   = (32'(ball_id_i) < BALLS);

  always_comb begin
    busy_d = busy_q;
    priority if (in_acc && in_range) begin
      busy_d = 1'b1;
    end else if (occ_fire) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (occ_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input beat capture; the fields stay put until the next accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      rad_q    <= radius_i;
      idx_q    <= ball_id_i[IdxW-1:0];
    end
  end

  osca_search u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc & in_range),
    .pos_i    (pos_q),
    .radius_i (rad_q),
    .done_o   (srch_done),
    .res_o    (srch_res)
  );

  osca_occupancy #(
    .DEPTH (Depth)
  ) u_occupancy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (srch_done),
    .idx_i       (idx_q),
    .cell_i      (srch_res.node),
    .res_ready_i (occ_ready),
    .res_valid_o (occ_valid),
    .res_o       (occ_res)
  );

  // Output register: holds the beat for as long as the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (occ_fire) begin
      out_srch_q <= srch_res;
      out_occ_q  <= occ_res;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign cell_id_o               = out_srch_q.node;
  assign cell_level_o            = out_srch_q.level;
  assign outside_root_o          = out_srch_q.outside;
  assign moved_o                 = out_occ_q.moved;
  assign old_cell_id_o           = out_occ_q.old_cell;
  assign had_old_cell_o          = out_occ_q.had_old;
  assign cell_became_occupied_o  = out_occ_q.became_occ;
  assign old_cell_became_empty_o = out_occ_q.became_emp;

endmodule

`default_nettype wire

FILE: sim/osca_placement_checker.sv
// ----------------------------------------------------------------------------
// Octree placement checker
// Watches both channels of the cell assignment block, predicts each result
// from its own octree search and occupancy tables, and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module osca_placement_checker
  import osca_pkg::*;
#(
  parameter int unsigned BALLS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [IdW-1:0]      ball_id_i,
  input  pos_t                pos_x_i,
  input  pos_t                pos_y_i,
  input  pos_t                pos_z_i,
  input  logic [RadW-1:0]     radius_i,

  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cell_t               cell_id_i,
  input  lvl_t                cell_level_i,
  input  logic                moved_i,
  input  cell_t               old_cell_id_i,
  input  logic                had_old_cell_i,
  input  logic                cell_became_occupied_i,
  input  logic                old_cell_became_empty_i,
  input  logic                outside_root_i,

  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int MaxReported = 10;

  typedef struct packed {
    cell_t node;
    lvl_t  level;
    logic  moved;
    cell_t old_cell;
    logic  had_old;
    logic  became_occ;
    logic  became_emp;
    logic  outside;
  } placement_t;

  // Shadow copy of the block's sphere and cell tables.
  int unsigned spheres_in_cell [NumCells];
  bit          sphere_placed   [BALLS];
  int unsigned sphere_cell     [BALLS];

  placement_t  expected_placements [$];
  int          results_seen;

  initial begin
    foreach (spheres_in_cell[i]) spheres_in_cell[i] = 0;
    foreach (sphere_placed[i]) begin
      sphere_placed[i] = 1'b0;
      sphere_cell[i]   = 0;
    end
    results_seen = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Inclusive bounds, shrunk by the radius on every axis.
  function automatic bit cell_holds(input int cx, input int cy, input int cz, input int h,
                                    input int px, input int py, input int pz, input int r);
    return (cx - h + r <= px) && (px <= cx + h - r) &&
           (cy - h + r <= py) && (py <= cy + h - r) &&
           (cz - h + r <= pz) && (pz <= cz + h - r);
  endfunction

  // Depth-first search with an explicit stack. The first deeper hit below a
  // child ends the whole search; otherwise the last fitting child wins.
  function automatic void find_deepest_cell(input int px, input int py, input int pz,
                                            input int r, output int node,
                                            output int level, output bit outside);
    int cx [LAYERS];
    int cy [LAYERS];
    int cz [LAYERS];
    int npos [LAYERS];
    int kbase [LAYERS];
    int kidx [LAYERS];
    bit hit [LAYERS];
    int best_cell [LAYERS];
    int best_lvl [LAYERS];
    int lv, q, k, ccx, ccy, ccz, cpos;
    bit done;
    node    = 0;
    level   = 0;
    outside = !cell_holds(0, 0, 0, ROOT_HALF, px, py, pz, r);
    if (outside) return;
    lv       = 0;
    cx[0]    = 0;
    cy[0]    = 0;
    cz[0]    = 0;
    npos[0]  = 0;
    kbase[0] = 1;
    kidx[0]  = 0;
    hit[0]   = 1'b0;
    done     = 1'b0;
    while (!done) begin
      if (kidx[lv] == 8) begin
        if (hit[lv] && lv > 0) begin
          node  = best_cell[lv];
          level = best_lvl[lv];
          done  = 1'b1;
        end else if (lv == 0) begin
          if (hit[0]) begin
            node  = best_cell[0];
            level = best_lvl[0];
          end
          done = 1'b1;
        end else begin
          lv = lv - 1;
          kidx[lv] = kidx[lv] + 1;
        end
      end else begin
        q    = ROOT_HALF >> (lv + 1);
        k    = kidx[lv];
        ccx  = cx[lv] + (((k & 4) != 0) ? q : -q);
        ccy  = cy[lv] + (((k & 2) != 0) ? q : -q);
        ccz  = cz[lv] + (((k & 1) != 0) ? q : -q);
        cpos = npos[lv] * 8 + k;
        if (cell_holds(ccx, ccy, ccz, q, px, py, pz, r)) begin
          hit[lv]       = 1'b1;
          best_cell[lv] = kbase[lv] + cpos;
          best_lvl[lv]  = lv + 1;
          if (lv + 1 < int'(LAYERS)) begin
            cx[lv+1]    = ccx;
            cy[lv+1]    = ccy;
            cz[lv+1]    = ccz;
            npos[lv+1]  = cpos;
            kbase[lv+1] = kbase[lv] * 8 + 1;
            kidx[lv+1]  = 0;
            hit[lv+1]   = 1'b0;
            lv = lv + 1;
          end else begin
            kidx[lv] = kidx[lv] + 1;
          end
        end else begin
          kidx[lv] = kidx[lv] + 1;
        end
      end
    end
  endfunction

  // Places one sphere in the shadow tables and returns the expected report.
  function automatic placement_t predict_placement(input int id, input int px, input int py,
                                                   input int pz, input int r);
    placement_t res;
    int node, level, old;
    bit outside, had, moved;
    find_deepest_cell(px, py, pz, r, node, level, outside);
    had   = sphere_placed[id];
    old   = had ? sphere_cell[id] : 0;
    moved = !had || (old != node);
    res            = '0;
    res.node       = cell_t'(node);
    res.level      = lvl_t'(level);
    res.moved      = moved;
    res.old_cell   = cell_t'(old);
    res.had_old    = had;
    res.outside    = outside;
    if (moved) begin
      res.became_occ = (spheres_in_cell[node] == 0);
      spheres_in_cell[node]++;
      if (had && spheres_in_cell[old] > 0) begin
        spheres_in_cell[old]--;
        res.became_emp = (spheres_in_cell[old] == 0);
      end
      sphere_cell[id]   = node;
      sphere_placed[id] = 1'b1;
    end
    return res;
  endfunction

  function automatic string placement_text(input placement_t p);
    return $sformatf("cell %0d level %0d moved %0b old %0d had %0b occ %0b emp %0b out %0b",
                     p.node, p.level, p.moved, p.old_cell, p.had_old, p.became_occ,
                     p.became_emp, p.outside);
  endfunction

  always @(posedge clk_i) begin
    placement_t got, exp;
    bit         bad;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i && ball_id_i < BALLS) begin
        exp = predict_placement(int'(ball_id_i), int'(pos_x_i), int'(pos_y_i),
                                int'(pos_z_i), int'(radius_i));
        expected_placements = {expected_placements, exp};
      end
      if (out_valid_i && !out_stall_i) begin
        got = {cell_id_i, cell_level_i, moved_i, old_cell_id_i, had_old_cell_i,
               cell_became_occupied_i, old_cell_became_empty_i, outside_root_i};
        if (expected_placements.size() == 0) begin
          if (fail_count_o < MaxReported)
            $display("result %0d arrived with nothing expected: %s", results_seen,
                     placement_text(got));
          fail_count_o = fail_count_o + 1;
        end else begin
          exp = expected_placements.pop_front();
          bad = (got.node !== exp.node) || (got.level !== exp.level) ||
                (got.moved !== exp.moved) || (got.old_cell !== exp.old_cell) ||
                (got.had_old !== exp.had_old) || (got.became_occ !== exp.became_occ) ||
                (got.became_emp !== exp.became_emp) || (got.outside !== exp.outside);
          if (bad) begin
            if (fail_count_o < MaxReported)
              $display("result %0d mismatch\n  expected %s\n  actual   %s", results_seen,
                       placement_text(exp), placement_text(got));
            fail_count_o = fail_count_o + 1;
          end
        end
        results_seen = results_seen + 1;
      end
      pending_o = expected_placements.size();
    end
  end

endmodule

FILE: sim/octree_sphere_cell_assign_tb.sv
// ----------------------------------------------------------------------------
// Octree sphere cell assignment testbench
// Drives sphere placements through the block under four handshake regimes
// and lets a separate checker judge every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module octree_sphere_cell_assign_tb;
  import osca_pkg::*;

  // The block has no configuration, so the whole run is one stream of
  // placements. A short directed part opens it, hitting the tie rule at the
  // cell corners, exact fits at each level, the root boundary, spheres that
  // overhang the root, oversized radii, repeats that leave a sphere in place,
  // and moves that empty and fill cells. The random part follows in four
  // phases that differ only in how often each side holds off.

  localparam int unsigned BALLS          = 256;
  localparam int          RandomPerPhase = 375;
  localparam int          DrainCycles    = 2 * (LAYERS + 6);
  // Quiet cycles tolerated before the run is declared hung. A correct run
  // is not expected to go this long without a beat on either side, even
  // under the heaviest stalling.
  localparam int          WatchdogLimit  = 5000;

  typedef struct packed {
    logic [IdW-1:0]  id;
    pos_t            x;
    pos_t            y;
    pos_t            z;
    logic [RadW-1:0] r;
  } sphere_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;

  logic            in_valid;
  logic            in_stall;
  logic [IdW-1:0]  ball_id;
  pos_t            pos_x;
  pos_t            pos_y;
  pos_t            pos_z;
  logic [RadW-1:0] radius;

  logic            out_valid;
  logic            out_stall = 1'b0;
  cell_t           cell_id;
  lvl_t            cell_level;
  logic            moved;
  cell_t           old_cell_id;
  logic            had_old_cell;
  logic            cell_became_occupied;
  logic            old_cell_became_empty;
  logic            outside_root;

  int              fail_count;
  int              pending;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int              idle_pct  = 0;
  int              stall_pct = 0;

  // Recently sent spheres, replayed now and then so that spheres stay put.
  sphere_t         recent [16];
  int              recent_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  octree_sphere_cell_assign #(
    .BALLS(BALLS)
  ) i_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .ball_id_i               (ball_id),
    .pos_x_i                 (pos_x),
    .pos_y_i                 (pos_y),
    .pos_z_i                 (pos_z),
    .radius_i                (radius),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .cell_id_o               (cell_id),
    .cell_level_o            (cell_level),
    .moved_o                 (moved),
    .old_cell_id_o           (old_cell_id),
    .had_old_cell_o          (had_old_cell),
    .cell_became_occupied_o  (cell_became_occupied),
    .old_cell_became_empty_o (old_cell_became_empty),
    .outside_root_o          (outside_root)
  );

  osca_placement_checker #(
    .BALLS(BALLS)
  ) i_checker (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid),
    .in_stall_i              (in_stall),
    .ball_id_i               (ball_id),
    .pos_x_i                 (pos_x),
    .pos_y_i                 (pos_y),
    .pos_z_i                 (pos_z),
    .radius_i                (radius),
    .out_valid_i             (out_valid),
    .out_stall_i             (out_stall),
    .cell_id_i               (cell_id),
    .cell_level_i            (cell_level),
    .moved_i                 (moved),
    .old_cell_id_i           (old_cell_id),
    .had_old_cell_i          (had_old_cell),
    .cell_became_occupied_i  (cell_became_occupied),
    .old_cell_became_empty_i (old_cell_became_empty),
    .outside_root_i          (outside_root),
    .fail_count_o            (fail_count),
    .pending_o               (pending)
  );

  // The receiver decides afresh at every falling edge whether to stall.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sends one beat. Idle cycles come first, then the beat is held, payload
  // unchanged, until a rising edge sees the block not stalling.
  task automatic send_sphere(input sphere_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    ball_id  <= s.id;
    pos_x    <= s.x;
    pos_y    <= s.y;
    pos_z    <= s.z;
    radius   <= s.r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    recent[recent_count % 16] = s;
    recent_count = recent_count + 1;
  endtask

  task automatic place(input int id, input int x, input int y, input int z, input int r);
    sphere_t s;
    s.id = id[IdW-1:0];
    s.x  = pos_t'(x);
    s.y  = pos_t'(y);
    s.z  = pos_t'(z);
    s.r  = r[RadW-1:0];
    send_sphere(s);
  endtask

  // Coordinates mostly fall inside the root, often right on a cell boundary or a
  // deepest cell's centre or one step either side of it, and sometimes anywhere in range.
  function automatic int random_coord();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return int'($urandom_range(16384)) - 8192;
    if (roll < 8) return int'($urandom_range(8)) * 2048 - 8192 + int'($urandom_range(2)) - 1;
    return int'(pos_t'($urandom));
  endfunction

  // Small radii let spheres reach the deepest level; larger ones push them
  // up the tree or out of the root, and a few go past the stated range.
  function automatic int random_radius();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom_range(1024);
    if (roll < 55) return int'($urandom_range(4)) * 2048;
    if (roll < 75) return $urandom_range(4096);
    if (roll < 87) return $urandom_range(8192);
    if (roll < 95) return $urandom_range(16384);
    return $urandom_range(32767);
  endfunction

  task automatic place_random();
    int id;
    if (recent_count > 0 && $urandom_range(99) < 12) begin
      send_sphere(recent[$urandom_range((recent_count < 16 ? recent_count : 16) - 1)]);
    end else begin
      // A small pool of ids keeps spheres moving between cells so that
      // counts rise and fall; the rest cover the whole id range.
      id = ($urandom_range(99) < 60) ? $urandom_range(15) : $urandom_range(255);
      place(id, random_coord(), random_coord(), random_coord(), random_radius());
    end
  endtask

  // Ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int idle_of [4];
    int stall_of [4];
    idle_of  = '{0, 57, 0, 11};
    stall_of = '{0, 0, 57, 11};
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    ball_id  = '0;
    pos_x    = '0;
    pos_y    = '0;
    pos_z    = '0;
    radius   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A point at the centre touches every child; the first child wins and
    // its own last fitting child is taken.
    place(0, 0, 0, 0, 0);
    // The same sphere again stays where it is.
    place(0, 0, 0, 0, 0);
    // A sphere whose radius spans the whole root overhangs it and lands in the root.
    place(255, 0, 0, 0, 16384);
    // Corners of the root, both inclusive, and the first step outside.
    place(0, 8192, 8192, 8192, 0);
    place(1, -8192, -8192, -8192, 0);
    place(1, 8193, 0, 0, 0);
    // Coordinate and radius extremes, including a radius past the range.
    place(2, 32767, -32768, 0, 0);
    place(3, -32768, 32767, -32768, 32767);
    // Exact fits: a first level cell, the root itself, and just too big.
    place(4, 4096, -4096, 4096, 4096);
    place(5, 0, 0, 0, 8192);
    place(6, 0, 0, 0, 8193);
    // A deepest cell filled exactly, kept, then grown out of every child.
    place(7, 2048, 2048, -2048, 2048);
    place(7, 2048, 2048, -2048, 2048);
    place(7, 2048, 2048, -2048, 2049);
    // Points one step off the centre.
    place(8, 1, 1, 1, 1);
    place(9, -1, 0, 1, 0);
    // Moves back into and out of shared cells, emptying some on the way.
    place(0, 0, 0, 0, 0);
    place(255, 0, 0, 0, 0);
    place(4, 6144, 6144, 6144, 2048);
    place(0, 6144, 6144, 6144, 0);
    place(128, 16383, -16384, 8191, 1);
    place(127, -8191, 8191, -1, 0);
    place(5, -4096, 4096, -4096, 10922);
    place(6, 4095, -4097, 21845, 21845);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_of[phase];
      stall_pct = stall_of[phase];
      repeat (RandomPerPhase) place_random();
    end
    in_valid <= 1'b0;

    // Wait for the last results, then give the block time to misbehave.
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
